@@ rtl/core/ir_distance_median_linearizer_unit_assert.svh @@
// Assertion macros used by the checker file ird_chk.sv.
`ifndef IR_DISTANCE_MEDIAN_LINEARIZER_UNIT_ASSERT_SVH
`define IR_DISTANCE_MEDIAN_LINEARIZER_UNIT_ASSERT_SVH
// Implication checked on every clock, quiet during reset.
`define IRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define IRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/ird_pkg.sv @@
`default_nettype none
package ird_pkg;
  localparam int unsigned CHANNELS_DEF     = 4;
  localparam int unsigned WINDOW_DEF       = 5;
  localparam int unsigned TABLE_POINTS_DEF = 13;
  localparam int unsigned SAMPLE_W         = 12;
  localparam int unsigned DIST_W           = 7;
  localparam int unsigned FRAC_W           = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_SEARCH,
    ST_DIV,
    ST_NEXT,
    ST_OUT
  } ird_state_t;

  typedef struct packed {
    logic load;        // capture samples, write history
    logic sort_step;   // one odd-even pass on the window
    logic search_step; // one table point compared
    logic div_init;    // start interpolation divide
    logic div_step;    // one restoring divide bit
    logic store;       // write distance of current channel
    logic next_ch;     // advance channel
    logic bump_slot;   // advance history slot
  } ird_cmd_t;

  typedef struct packed {
    logic search_done;
    logic div_done;
    logic last_ch;
    logic sort_done;
  } ird_sts_t;

  function automatic logic [SAMPLE_W-1:0] cal_point(input logic [3:0] idx);
    logic [SAMPLE_W-1:0] p;
    case (idx)
      4'd0:  p = 12'd2930;
      4'd1:  p = 12'd2020;
      4'd2:  p = 12'd1600;
      4'd3:  p = 12'd1300;
      4'd4:  p = 12'd1110;
      4'd5:  p = 12'd980;
      4'd6:  p = 12'd860;
      4'd7:  p = 12'd780;
      4'd8:  p = 12'd720;
      4'd9:  p = 12'd660;
      4'd10: p = 12'd620;
      4'd11: p = 12'd560;
      4'd12: p = 12'd540;
      default: p = 12'd0;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/ird_ctrl.sv @@
`default_nettype none
module ird_ctrl import ird_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     filter_en,
  input  ird_sts_t      sts,
  output ird_cmd_t      cmd
);
  ird_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = filter_en ? ST_SORT : ST_SEARCH;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.sort_done) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.store = 1'b1;
        if (sts.last_ch) begin
          cmd.bump_slot = filter_en;
          state_nxt     = ST_OUT;
        end else begin
          cmd.next_ch = 1'b1;
          state_nxt   = filter_en ? ST_SORT : ST_SEARCH;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/ird_dp.sv @@
`default_nettype none
module ird_dp import ird_pkg::*; #(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned WINDOW       = WINDOW_DEF,
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [CHANNELS-1:0][SAMPLE_W-1:0]   samples,
  input  wire logic                                filter_en,
  input  ird_cmd_t                                 cmd,
  output ird_sts_t                                 sts,
  output logic [CHANNELS-1:0][DIST_W-1:0]          dists
);
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned PASS_W = $clog2(WINDOW + 1);
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned NUM_W  = SAMPLE_W + 3;

  logic [CHANNELS-1:0][SAMPLE_W-1:0]            smp_r;
  logic [CHANNELS-1:0][WINDOW-1:0][SAMPLE_W-1:0] hist_r;
  logic [SLOT_W-1:0]                            slot_r;
  logic [CH_W-1:0]                              ch_r;
  logic [WINDOW-1:0][SAMPLE_W-1:0]              win_r, win_nxt, win_init;
  logic [PASS_W-1:0]                            pass_r;
  logic [IDX_W-1:0]                             idx_r;
  logic [SAMPLE_W-1:0]                          val_r, val_init;
  logic [NUM_W-1:0]                             num_r;
  logic [SAMPLE_W-1:0]                          den_r;
  logic [FRAC_W-1:0]                            quo_r;
  logic [1:0]                                   dcnt_r;
  logic [DIST_W-1:0]                            base_r;
  logic                                         sat_r;
  logic [CHANNELS-1:0][DIST_W-1:0]              dist_r;
  logic [SAMPLE_W-1:0]                          pt_i, hi_pt;
  logic                                         stop;

  assign pt_i  = cal_point(idx_r[3:0]);
  assign hi_pt = cal_point(4'(idx_r - IDX_W'(1)));
  assign stop  = (idx_r == IDX_W'(TABLE_POINTS)) || (val_r > pt_i);

  assign sts.sort_done   = (pass_r == PASS_W'(WINDOW - 1));
  assign sts.search_done = stop;
  assign sts.div_done    = sat_r || (dcnt_r == 2'd2);
  assign sts.last_ch     = (ch_r == CH_W'(CHANNELS - 1));
  assign dists           = dist_r;

  // window and raw value for the channel about to start; channel 0 sees the
  // sample that is being written into its history on the same edge
  always_comb begin
    win_init = hist_r[ch_r + CH_W'(1)];
    val_init = smp_r[ch_r + CH_W'(1)];
    if (cmd.load) begin
      win_init = hist_r[0];
      val_init = samples[0];
      if (filter_en) win_init[slot_r] = samples[0];
    end
  end

  // one odd-even transposition pass
  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k + 1 < WINDOW; k++) begin
      if ((k % 2) == int'(pass_r[0]) && win_nxt[k] > win_nxt[k+1]) begin
        win_nxt[k]   = win_r[k+1];
        win_nxt[k+1] = win_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      slot_r <= '0;
      ch_r   <= '0;
    end else begin
      if (cmd.load) begin
        ch_r <= '0;
        if (filter_en) begin
          for (int c = 0; c < CHANNELS; c++) hist_r[c][slot_r] <= samples[c];
        end
      end
      if (cmd.next_ch)   ch_r <= ch_r + CH_W'(1);
      if (cmd.bump_slot) slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) smp_r <= samples;
    // reload the window whenever a channel starts
    if (cmd.load || cmd.next_ch) begin
      win_r  <= win_init;
      pass_r <= '0;
      idx_r  <= '0;
      val_r  <= val_init;
    end else if (cmd.sort_step) begin
      win_r  <= win_nxt;
      pass_r <= pass_r + PASS_W'(1);
      if (sts.sort_done) val_r <= win_nxt[WINDOW/2];
    end else if (cmd.search_step && !stop) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.store) dist_r[ch_r] <= base_r + DIST_W'(quo_r);
  end

  // restoring divide of 5*(hi-v) by (hi-lo), quotient < 5, three bits
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r  <= '0;
      dcnt_r <= '0;
      num_r  <= NUM_W'(hi_pt - val_r) * NUM_W'(5);
      den_r  <= hi_pt - pt_i;
      if (idx_r == '0) begin
        sat_r  <= 1'b1;
        base_r <= DIST_W'(10);
      end else if (idx_r == IDX_W'(TABLE_POINTS)) begin
        sat_r  <= 1'b1;
        base_r <= DIST_W'(10 + 5 * (TABLE_POINTS - 1));
      end else begin
        sat_r  <= 1'b0;
        base_r <= DIST_W'(10) + DIST_W'(5) * DIST_W'(idx_r - IDX_W'(1));
      end
    end else if (cmd.div_step && !sat_r) begin
      dcnt_r <= dcnt_r + 2'd1;
      if (num_r >= (NUM_W'(den_r) << (2 - dcnt_r))) begin
        num_r <= num_r - (NUM_W'(den_r) << (2 - dcnt_r));
        quo_r[2 - dcnt_r] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ir_distance_median_linearizer_unit.sv @@
`default_nettype none
// Channel | Signals                                   | Role
// in      | in_valid in_ready in_sample_ch0..3 (12b)  | four ADC samples per beat
// out     | out_valid out_ready out_dist_ch0..3 (7b)  | four distances per beat
// cfg     | cfg_valid cfg_ready cfg_filter_enable     | median filter on/off
// One beat at a time, channel by channel, through the shared sorter (WINDOW
// passes, when filtering), table scanner (up to TABLE_POINTS+1 steps) and
// bit-serial divider.
// Reset clears the history, slot and filter_enable. A stalled out beat holds.
module ir_distance_median_linearizer_unit import ird_pkg::*; #(
  parameter int unsigned WINDOW       = WINDOW_DEF,
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_sample_ch0,
  input  wire logic [SAMPLE_W-1:0] in_sample_ch1,
  input  wire logic [SAMPLE_W-1:0] in_sample_ch2,
  input  wire logic [SAMPLE_W-1:0] in_sample_ch3,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DIST_W-1:0]        out_dist_ch0,
  output logic [DIST_W-1:0]        out_dist_ch1,
  output logic [DIST_W-1:0]        out_dist_ch2,
  output logic [DIST_W-1:0]        out_dist_ch3,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_filter_enable
);
  logic filter_en_r;
  ird_cmd_t cmd;
  ird_sts_t sts;
  logic [CHANNELS_DEF-1:0][SAMPLE_W-1:0] smp;
  logic [CHANNELS_DEF-1:0][DIST_W-1:0]   dst;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
    end else if (cfg_valid) begin
      filter_en_r <= cfg_filter_enable;
    end
  end

  assign smp = {in_sample_ch3, in_sample_ch2, in_sample_ch1, in_sample_ch0};
  assign out_dist_ch0 = dst[0];
  assign out_dist_ch1 = dst[1];
  assign out_dist_ch2 = dst[2];
  assign out_dist_ch3 = dst[3];

  ird_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .filter_en(filter_en_r),
    .sts(sts), .cmd(cmd)
  );

  ird_dp #(.CHANNELS(CHANNELS_DEF), .WINDOW(WINDOW), .TABLE_POINTS(TABLE_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .samples(smp), .filter_en(filter_en_r),
    .cmd(cmd), .sts(sts), .dists(dst)
  );
endmodule
`default_nettype wire

@@ rtl/core/ird_chk.sv @@
`default_nettype none
`include "ir_distance_median_linearizer_unit_assert.svh"
module ird_chk import ird_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DIST_W-1:0] out_dist_ch0
);
  `IRD_ASSERT_IMP(a_dist_range, clk, rst_n, out_valid, out_dist_ch0 >= 7'd10 && out_dist_ch0 <= 7'd70)
  `IRD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `IRD_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `IRD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_dist_ch0))
endmodule

bind ir_distance_median_linearizer_unit ird_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_dist_ch0(out_dist_ch0)
);
`default_nettype wire

@@ tb/sv/ir_distance_median_linearizer_unit_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module ir_distance_median_linearizer_unit_test;
  import ird_pkg::*;

  localparam int unsigned NCH = 4;
  localparam int unsigned WIN = 5;
  localparam int unsigned NPTS = 13;
  localparam int unsigned RANDOM_BEATS = 1700;
  localparam int unsigned STALL_LIMIT = 20000;
  // wait after draining, longer than the worst beat
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [DIST_W-1:0] DIST_NEAR = 7'd10;
  localparam logic [DIST_W-1:0] DIST_FAR = 7'd70;
  localparam logic [DIST_W-1:0] NO_CHECK = '1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef struct packed {
    sample_t [NCH-1:0] samples;
  } sample_beat_t;
  typedef struct packed {
    dist_t [NCH-1:0] dists;
  } dist_beat_t;
  typedef struct packed {
    sample_t [NCH-1:0] samples;
    dist_t fixed_dist;  // NO_CHECK where the predictor decides
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_sample [NCH];
  logic out_valid;
  logic out_ready = 1'b0;
  dist_t out_dist [NCH];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_filter_enable = 1'b0;

  // Predictor state: mirror of the block's filter history and register.
  sample_t history [NCH][WIN];
  int unsigned history_slot;
  logic filter_on;

  dist_beat_t expected_dists [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  initial begin
    in_sample = '{default: '0};
  end

  always #5 clk = ~clk;

  ir_distance_median_linearizer_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_ch0     (in_sample[0]),
    .in_sample_ch1     (in_sample[1]),
    .in_sample_ch2     (in_sample[2]),
    .in_sample_ch3     (in_sample[3]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dist_ch0      (out_dist[0]),
    .out_dist_ch1      (out_dist[1]),
    .out_dist_ch2      (out_dist[2]),
    .out_dist_ch3      (out_dist[3]),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_filter_enable (cfg_filter_enable)
  );

  function automatic sample_t cal_knee(input int unsigned idx);
    sample_t knees [NPTS];
    knees = '{12'd2930, 12'd2020, 12'd1600, 12'd1300, 12'd1110, 12'd980, 12'd860,
              12'd780, 12'd720, 12'd660, 12'd620, 12'd560, 12'd540};
    return knees[idx];
  endfunction

  // Convert one ADC reading to cm: find the segment, interpolate, truncate.
  function automatic dist_t adc_to_cm(input sample_t v);
    int unsigned seg;
    int unsigned hi;
    int unsigned lo;
    seg = 0;
    while (seg < NPTS && v <= cal_knee(seg)) seg++;
    if (seg == 0) return DIST_NEAR;
    if (seg >= NPTS) return DIST_FAR;
    hi = cal_knee(seg - 1);
    lo = cal_knee(seg);
    return dist_t'(10 + 5 * (seg - 1) + (5 * (hi - v)) / (hi - lo));
  endfunction

  function automatic sample_t window_median(input sample_t w [WIN]);
    sample_t s [WIN];
    sample_t t;
    s = w;
    for (int a = 0; a < WIN; a++)
      for (int b = 0; b < WIN - 1 - a; b++)
        if (s[b] > s[b + 1]) begin
          t = s[b];
          s[b] = s[b + 1];
          s[b + 1] = t;
        end
    return s[WIN / 2];
  endfunction

  // Advance the filter history and return the distances this beat yields.
  function automatic dist_beat_t predict_distances(input sample_beat_t beat);
    dist_beat_t r;
    sample_t v;
    int unsigned slot;
    slot = (history_slot >= WIN) ? 0 : history_slot;
    for (int ch = 0; ch < NCH; ch++) begin
      v = beat.samples[ch];
      if (filter_on) begin
        history[ch][slot] = v;
        v = window_median(history[ch]);
      end
      r.dists[ch] = adc_to_cm(v);
    end
    if (filter_on) history_slot = (slot + 1 < WIN) ? slot + 1 : 0;
    return r;
  endfunction

  // Watchdog: count cycles without any beat on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random back-pressure, and check every result beat.
  always @(posedge clk) begin
    dist_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (expected_dists.size() == 0) begin
        $error("unexpected result beat");
        error_count++;
      end else begin
        want = expected_dists.pop_front();
        for (int ch = 0; ch < NCH; ch++)
          if (out_dist[ch] !== want.dists[ch]) begin
            $error("dist_ch%0d: expected %0d, got %0d", ch, want.dists[ch], out_dist[ch]);
            error_count++;
          end
      end
    end
    out_ready <= quiet_receiver ? 1'b1 : ($urandom_range(99) >= 15);
  end

  task automatic wait_cycles(input int unsigned n);
    repeat (n) @(posedge clk);
  endtask

  // Drop the sender and wait until every queued result has come.
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_dists.size() != 0 && guard < 100 * STALL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    wait_cycles(DRAIN_CYCLES);
  endtask

  task automatic write_filter_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_filter_enable <= en;
    do @(posedge clk); while (!cfg_ready);
    filter_on = en;
    cfg_valid <= 1'b0;
  endtask

  // Send one beat; the predicted result is queued at acceptance.
  // Valid stays high after the beat so the next one can follow at once.
  // fixed_dist, when set, also checks the prediction of every channel against it.
  task automatic send_samples(input sample_beat_t beat, input dist_t fixed_dist);
    dist_beat_t want;
    if (!quiet_sender)
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    for (int ch = 0; ch < NCH; ch++) in_sample[ch] <= beat.samples[ch];
    do @(posedge clk); while (!in_ready);
    want = predict_distances(beat);
    if (fixed_dist != NO_CHECK)
      for (int ch = 0; ch < NCH; ch++)
        if (want.dists[ch] != fixed_dist) begin
          $error("dist_ch%0d: expected %0d, got %0d (predictor)", ch, fixed_dist,
                 want.dists[ch]);
          error_count++;
        end
    expected_dists.push_back(want);
    beats_in++;
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(4095));
      1: return sample_t'($urandom_range(2930, 500));
      2: return sample_t'(cal_knee($urandom_range(NPTS - 1)) + $urandom_range(2) - 1);
      default: return sample_t'($urandom_range(2930, 540));
    endcase
  endfunction

  directed_row_t directed_rows [] = '{
    // raw mode: extremes and the saturation edges
    '{'{12'd0, 12'd0, 12'd0, 12'd0}, DIST_FAR},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095}, DIST_NEAR},
    '{'{12'd2931, 12'd2931, 12'd2931, 12'd2931}, DIST_NEAR},
    '{'{12'd2930, 12'd2930, 12'd2930, 12'd2930}, NO_CHECK},
    '{'{12'd540, 12'd540, 12'd540, 12'd540}, DIST_FAR},
    '{'{12'd541, 12'd561, 12'd1599, 12'd2021}, NO_CHECK},
    '{'{12'd2475, 12'd1000, 12'd700, 12'd600}, NO_CHECK},
    '{'{12'd2730, 12'd1365, 12'd682, 12'd3412}, NO_CHECK},
    '{'{12'd3072, 12'd1023, 12'd2048, 12'd4094}, NO_CHECK},
    '{'{12'd1, 12'd2, 12'd4, 12'd8}, DIST_FAR}
  };

  initial begin
    sample_beat_t beat;
    int unsigned results_goal;
    history = '{default: '{default: '0}};
    history_slot = 0;
    filter_on = 1'b0;
    wait_cycles(5);
    rst_n <= 1'b1;
    @(posedge clk);

    // Raw calibration, register left at its reset value.
    foreach (directed_rows[r]) begin
      beat.samples = directed_rows[r].samples;
      send_samples(beat, directed_rows[r].fixed_dist);
    end
    drain_results();

    // Filter start-up: reset zeros dominate the median for the first beats.
    write_filter_enable(1'b1);
    for (int k = 0; k < 7; k++) begin
      for (int ch = 0; ch < NCH; ch++)
        beat.samples[ch] = (k < 2) ? 12'd4095 : sample_t'(600 + 300 * k + 40 * ch);
      send_samples(beat, (k < 2) ? DIST_FAR : NO_CHECK);
    end
    drain_results();

    // Random phases, toggling the filter between them; random readings with
    // uniform outliers mixed in keep the median busy.
    results_goal = RANDOM_BEATS;
    for (int phase = 0; phase < 6; phase++) begin
      write_filter_enable(phase[0] ? 1'b0 : 1'b1);
      quiet_sender = (phase == 2);
      quiet_receiver = (phase == 2);
      for (int k = 0; k < results_goal / 6; k++) begin
        for (int ch = 0; ch < NCH; ch++)
          beat.samples[ch] = ($urandom_range(9) < 2) ? sample_t'($urandom_range(4095))
                                                      : random_sample();
        send_samples(beat, NO_CHECK);
        if (k == 40) begin
          // hold the sender until the result queue is empty
          in_valid <= 1'b0;
          while (expected_dists.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    drain_results();

    $display("Sent %0d sample beats, received %0d distance beats, filter on and off.",
             beats_in, beats_out);
    if (error_count == 0 && expected_dists.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_dists.size() != 0) $error("%0d results never arrived", expected_dists.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
